/* design/rlnc_gf256_encoder_macros.svh */
`ifndef RLNC_GF256_ENCODER_MACROS_SVH
`define RLNC_GF256_ENCODER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define RLNC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlnc assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define RLNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlnc assertion failed");

`endif

/* design/rlnc_pkg.sv */
`timescale 1ns / 1ps
package rlnc_pkg;

   localparam int MAX_PACKETS = 16;
   localparam int MAX_BYTES   = 256;
   localparam int PKT_W       = $clog2(MAX_PACKETS);
   localparam int BYTE_W      = $clog2(MAX_BYTES);
   localparam int CNT_W       = $clog2(MAX_PACKETS + 1);
   localparam int LEN_W       = 9;
   localparam int ADDR_W      = PKT_W + BYTE_W;

   localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
   localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
   localparam logic [7:0]  GF_POLY = 8'h1b;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [2:0] OP_BYTE  = 3'd0;
   localparam logic [2:0] OP_END   = 3'd1;
   localparam logic [2:0] OP_DRAW  = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_PKTS   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_NOT_DRAWN = 3'd4;

   localparam logic [3:0] REG_SEED_ADDR = 4'd0;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DRAW_TEST, S_MUL0, S_MUL1, S_MUL2, S_DRAW_CHECK,
      S_READ, S_DRAIN, S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MUL_NONE, MUL_LOW, MUL_CROSS_A, MUL_CROSS_B
   } mul_op_type;

   typedef struct packed {
      logic             latch;
      logic             emit;
      logic             take_coeff;
      logic             rd_issue;
      logic             acc_clear;
      mul_op_type       mul_op;
      logic [PKT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       count_zero;
      logic       read_ok;
      logic       idx_last;
      logic       lcg_zero;
      logic       top_zero;
      logic       out_free;
   } dp_status_type;

endpackage

/* design/rlnc_ctrl.sv */
`timescale 1ns / 1ps
module rlnc_ctrl import rlnc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type st,
   output cmd_type       cmd
);

   state_type        state_ff, state_in;
   logic [PKT_W-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cmd            = '0;
      cmd.mul_op     = MUL_NONE;
      cmd.idx        = idx_ff;
      req_stall      = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in = '0;
            case (st.op)
               OP_BYTE, OP_END, OP_CLEAR: state_in = S_EMIT;
               OP_DRAW: state_in = st.count_zero ? S_EMIT : S_DRAW_TEST;
               OP_READ: begin
                  if (st.read_ok) begin
                     cmd.acc_clear = 1'b1;
                     state_in      = S_READ;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DRAW_TEST: begin
            if (st.lcg_zero) begin
               cmd.take_coeff = 1'b1;
               state_in       = S_EMIT;
            end else begin
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_op = MUL_LOW;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_op = MUL_CROSS_A;
            state_in   = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_op = MUL_CROSS_B;
            state_in   = S_DRAW_CHECK;
         end
         S_DRAW_CHECK: begin
            // step again on a zero state or a zero top byte
            if (st.lcg_zero || st.top_zero) begin
               state_in = S_MUL0;
            end else begin
               cmd.take_coeff = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            if (st.idx_last) state_in = S_DRAIN;
            else idx_in = idx_ff + 1'b1;
         end
         S_DRAIN: state_in = S_EMIT;
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.op == OP_DRAW && !st.count_zero && !st.idx_last) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_DRAW_TEST;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* design/rlnc_datapath.sv */
`timescale 1ns / 1ps
module rlnc_datapath import rlnc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output dp_status_type st,
   input  logic [2:0]    req_op,
   input  logic [7:0]    req_data_byte,
   input  logic [8:0]    req_byte_index,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_coeff,
   output logic [3:0]    rsp_packet_index,
   output logic [7:0]    rsp_coded_byte,
   output logic [8:0]    rsp_coded_length,
   output logic [2:0]    rsp_status,
   output logic          rsp_last,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [3:0]    paddr,
   input  logic [63:0]   pwdata,
   output logic [63:0]   prdata,
   output logic          pready
);

   function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] a;
      logic [7:0] p;
      a = x;
      p = '0;
      for (int k = 0; k < 8; k++) begin
         if (y[k]) p = p ^ a;
         a = a[7] ? ((a << 1) ^ GF_POLY) : (a << 1);
      end
      return p;
   endfunction

   logic [7:0] store_mem [MAX_PACKETS*MAX_BYTES];
   logic [LEN_W-1:0] len_mem [MAX_PACKETS];
   logic [7:0] coeff_mem [MAX_PACKETS];

   logic [2:0]       op_ff;
   logic [7:0]       data_ff;
   logic [8:0]       bidx_ff;
   logic [63:0]      seed_ff, lcg_ff, acc_ff;
   logic [CNT_W-1:0] count_ff;
   logic [LEN_W-1:0] fill_ff, longest_ff;
   logic             cvalid_ff;
   logic [7:0]       coeff_ff, code_ff;
   logic [7:0]       rd_data_ff, stg_coeff_ff;
   logic [LEN_W-1:0] stg_len_ff;
   logic             stg_valid_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_coeff_ff, rsp_coded_ff;
   logic [3:0]       rsp_pi_ff;
   logic [8:0]       rsp_len_ff;
   logic [2:0]       rsp_status_ff;
   logic             rsp_last_ff;

   logic             cfg_wr, full_pkts, full_bytes;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      prod;
   logic [LEN_W-1:0] close_len, sel_len;
   logic [CNT_W-1:0] count_m1;
   logic [7:0]       sel_byte;
   logic [7:0]       res_coeff, res_coded;
   logic [3:0]       res_pi;
   logic [8:0]       res_len;
   logic [2:0]       res_status;
   logic             res_last;

   assign cfg_wr     = psel && penable && pwrite && (paddr == REG_SEED_ADDR);
   assign pready     = 1'b1;
   assign prdata     = (paddr == REG_SEED_ADDR) ? seed_ff : 64'd0;
   assign full_pkts  = (count_ff >= CNT_W'(MAX_PACKETS));
   assign full_bytes = (fill_ff >= LEN_W'(MAX_BYTES));
   assign close_len  = fill_ff + 1'b1;
   assign count_m1   = count_ff - 1'b1;

   assign st.op         = op_ff;
   assign st.count_zero = (count_ff == '0);
   assign st.read_ok    = (count_ff != '0) && cvalid_ff && (bidx_ff < longest_ff);
   assign st.idx_last   = ({1'b0, cmd.idx} == count_m1);
   assign st.lcg_zero   = (lcg_ff == '0);
   assign st.top_zero   = (lcg_ff[63:56] == '0);
   assign st.out_free   = !rsp_valid_ff || !rsp_stall;

   // 64-bit LCG product built from three 32x32 partial products
   always_comb begin
      case (cmd.mul_op)
         MUL_LOW:     begin mul_a = lcg_ff[31:0];  mul_b = LCG_MUL[31:0];  end
         MUL_CROSS_A: begin mul_a = lcg_ff[63:32]; mul_b = LCG_MUL[31:0];  end
         MUL_CROSS_B: begin mul_a = lcg_ff[31:0];  mul_b = LCG_MUL[63:32]; end
         default:     begin mul_a = '0;            mul_b = '0;             end
      endcase
      prod = mul_a * mul_b;
   end

   // padding byte right after a packet, zeros past it
   always_comb begin
      sel_len = stg_len_ff;
      if (bidx_ff < sel_len) sel_byte = rd_data_ff;
      else if (bidx_ff == sel_len) sel_byte = PAD_BYTE;
      else sel_byte = 8'd0;
   end

   always_comb begin
      res_coeff  = '0;
      res_pi     = '0;
      res_coded  = '0;
      res_len    = longest_ff;
      res_status = ST_OK;
      res_last   = 1'b1;
      case (op_ff)
         OP_BYTE: begin
            if (full_pkts || full_bytes) res_status = ST_FULL;
            else res_pi = count_ff[3:0];
         end
         OP_END: begin
            if (full_pkts) begin
               res_status = ST_FULL;
            end else begin
               res_pi = count_ff[3:0];
               if (close_len > longest_ff) res_len = close_len;
            end
         end
         OP_DRAW: begin
            if (count_ff == '0) begin
               res_status = ST_NO_PKTS;
               res_len    = '0;
            end else begin
               res_coeff = coeff_ff;
               res_pi    = 4'(cmd.idx);
               res_last  = st.idx_last;
            end
         end
         OP_READ: begin
            if (count_ff == '0) begin
               res_status = ST_NO_PKTS;
               res_len    = '0;
            end else if (!cvalid_ff) begin
               res_status = ST_NOT_DRAWN;
            end else if (bidx_ff >= longest_ff) begin
               res_status = ST_RANGE;
            end else begin
               res_coded = code_ff;
            end
         end
         default: res_len = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit && op_ff == OP_BYTE && !full_pkts && !full_bytes)
         store_mem[{count_ff[PKT_W-1:0], fill_ff[BYTE_W-1:0]}] <= data_ff;
      if (cmd.rd_issue)
         rd_data_ff <= store_mem[{cmd.idx, bidx_ff[BYTE_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit && op_ff == OP_END && !full_pkts)
         len_mem[count_ff[PKT_W-1:0]] <= fill_ff;
      if (cmd.emit && op_ff == OP_DRAW && count_ff != '0)
         coeff_mem[cmd.idx] <= coeff_ff;
      stg_len_ff   <= len_mem[cmd.idx];
      stg_coeff_ff <= coeff_mem[cmd.idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_op;
         data_ff <= req_data_byte;
         bidx_ff <= req_byte_index;
      end
      if (cmd.take_coeff) coeff_ff <= st.lcg_zero ? 8'd1 : lcg_ff[63:56];
      if (cmd.mul_op == MUL_LOW) acc_ff <= prod;
      else if (cmd.mul_op == MUL_CROSS_A) acc_ff <= acc_ff + {prod[31:0], 32'd0};
      if (cmd.acc_clear) code_ff <= '0;
      else if (stg_valid_ff) code_ff <= code_ff ^ gf_mul(stg_coeff_ff, sel_byte);
      if (cmd.emit) begin
         rsp_coeff_ff  <= res_coeff;
         rsp_pi_ff     <= res_pi;
         rsp_coded_ff  <= res_coded;
         rsp_len_ff    <= res_len;
         rsp_status_ff <= res_status;
         rsp_last_ff   <= res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         lcg_ff       <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         longest_ff   <= '0;
         cvalid_ff    <= 1'b0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= cmd.rd_issue;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (cfg_wr) begin
            seed_ff <= pwdata;
            lcg_ff  <= pwdata;
         end else if (cmd.mul_op == MUL_CROSS_B) begin
            lcg_ff <= acc_ff + {prod[31:0], 32'd0} + LCG_INC;
         end
         if (cmd.emit) begin
            case (op_ff)
               OP_BYTE: if (!full_pkts && !full_bytes) fill_ff <= fill_ff + 1'b1;
               OP_END: begin
                  if (!full_pkts) begin
                     count_ff  <= count_ff + 1'b1;
                     fill_ff   <= '0;
                     cvalid_ff <= 1'b0;
                     if (close_len > longest_ff) longest_ff <= close_len;
                  end
               end
               OP_DRAW: if (count_ff != '0 && st.idx_last) cvalid_ff <= 1'b1;
               OP_CLEAR: begin
                  count_ff   <= '0;
                  fill_ff    <= '0;
                  longest_ff <= '0;
                  cvalid_ff  <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coeff        = rsp_coeff_ff;
   assign rsp_packet_index = rsp_pi_ff;
   assign rsp_coded_byte   = rsp_coded_ff;
   assign rsp_coded_length = rsp_len_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* design/rlnc_gf256_encoder.sv */
`timescale 1ns / 1ps
// Load, end-packet and clear items: registered, decoded, then emitted; one item at a time.
// Coded-byte read: packets are read one per cycle from the single store port.
// Draw: per item a test, then per generator step three partial products on the shared
// 32x32 multiplier and a check, then the result.
// Synchronous active-high reset empties the store, clears the draw and zeroes seed/state.
`include "rlnc_gf256_encoder_macros.svh"
module rlnc_gf256_encoder import rlnc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [8:0]  req_byte_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_coeff,
   output logic [3:0]  rsp_packet_index,
   output logic [7:0]  rsp_coded_byte,
   output logic [8:0]  rsp_coded_length,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   cmd_type       cmd;
   dp_status_type st;
   logic          mid_draw_emit;

   rlnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   rlnc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .req_byte_index   (req_byte_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coeff        (rsp_coeff),
      .rsp_packet_index (rsp_packet_index),
      .rsp_coded_byte   (rsp_coded_byte),
      .rsp_coded_length (rsp_coded_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   assign mid_draw_emit = cmd.emit && !st.idx_last && st.op == OP_DRAW && !st.count_zero;

   `RLNC_ASSERT_SAME(a_emit_slot_free, clock, reset, cmd.emit, st.out_free)
   `RLNC_ASSERT_SAME(a_read_needs_draw, clock, reset, cmd.rd_issue, st.read_ok)
   `RLNC_ASSERT_NEXT(a_mid_result_ok, clock, reset, mid_draw_emit, rsp_valid && !rsp_last && rsp_status == ST_OK)

endmodule

/* dv/rlnc_stream_checker.sv */
`timescale 1ns / 1ps
module rlnc_stream_checker import rlnc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [8:0]  req_byte_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_coeff,
   input  logic [3:0]  rsp_packet_index,
   input  logic [7:0]  rsp_coded_byte,
   input  logic [8:0]  rsp_coded_length,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output int          mismatches,
   output int          pending
);

   typedef struct packed {
      logic [7:0] coeff;
      logic [3:0] pkt;
      logic [7:0] cbyte;
      logic [8:0] clen;
      logic [2:0] status;
      logic       last;
   } coded_rsp_type;

   coded_rsp_type coded_q[$];
   logic [7:0]  pkt_bytes [MAX_PACKETS][MAX_BYTES];
   logic [8:0]  pkt_len [MAX_PACKETS];
   logic [7:0]  pkt_coeff [MAX_PACKETS];
   logic [63:0] gen_state;
   int          n_pkts;
   int          fill;
   bit          drawn;

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic logic [7:0] gf_mul8(logic [7:0] x, logic [7:0] y);
      logic [8:0] a;
      logic [7:0] p;
      a = {1'b0, x};
      p = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (y[k]) p ^= a[7:0];
         a = a << 1;
         if (a[8]) a ^= {1'b1, GF_POLY};
      end
      return p;
   endfunction

   // step the generator, skipping zero states and zero top bytes
   function automatic logic [7:0] next_coeff();
      logic [7:0] v;
      if (gen_state == 64'd0) return 8'd1;
      do begin
         gen_state = gen_state * LCG_MUL + LCG_INC;
         v = gen_state[63:56];
      end while (gen_state == 64'd0 || v == 8'd0);
      return v;
   endfunction

   function automatic logic [8:0] coded_len();
      int m;
      m = 0;
      for (int i = 0; i < n_pkts; i++)
         if (pkt_len[i] + 1 > m) m = pkt_len[i] + 1;
      return 9'(m);
   endfunction

   task automatic push_rsp(logic [7:0] c, int pi, logic [7:0] cb, logic [8:0] len,
                           logic [2:0] st, logic lst);
      coded_rsp_type e;
      e.coeff = c;
      e.pkt = 4'(pi);
      e.cbyte = cb;
      e.clen = len;
      e.status = st;
      e.last = lst;
      coded_q.insert(coded_q.size(), e);
   endtask

   task automatic predict(logic [2:0] op, logic [7:0] db, logic [8:0] bi);
      logic [8:0] len;
      logic [7:0] acc;
      logic [7:0] b;
      len = coded_len();
      case (op)
         OP_BYTE: begin
            if (n_pkts >= MAX_PACKETS || fill >= MAX_BYTES) begin
               push_rsp(0, 0, 0, len, ST_FULL, 1);
            end else begin
               pkt_bytes[n_pkts][fill] = db;
               fill++;
               push_rsp(0, n_pkts, 0, len, ST_OK, 1);
            end
         end
         OP_END: begin
            if (n_pkts >= MAX_PACKETS) begin
               push_rsp(0, 0, 0, len, ST_FULL, 1);
            end else begin
               pkt_len[n_pkts] = 9'(fill);
               n_pkts++;
               fill = 0;
               drawn = 0;
               push_rsp(0, n_pkts - 1, 0, coded_len(), ST_OK, 1);
            end
         end
         OP_DRAW: begin
            if (n_pkts == 0) begin
               push_rsp(0, 0, 0, 0, ST_NO_PKTS, 1);
            end else begin
               for (int i = 0; i < n_pkts; i++) begin
                  pkt_coeff[i] = next_coeff();
                  push_rsp(pkt_coeff[i], i, 0, len, ST_OK, i + 1 == n_pkts);
               end
               drawn = 1;
            end
         end
         OP_READ: begin
            if (n_pkts == 0) push_rsp(0, 0, 0, 0, ST_NO_PKTS, 1);
            else if (!drawn) push_rsp(0, 0, 0, len, ST_NOT_DRAWN, 1);
            else if (bi >= len) push_rsp(0, 0, 0, len, ST_RANGE, 1);
            else begin
               acc = 8'h00;
               for (int i = 0; i < n_pkts; i++) begin
                  if (bi < pkt_len[i]) b = pkt_bytes[i][bi[7:0]];
                  else if (bi == pkt_len[i]) b = PAD_BYTE;
                  else b = 8'h00;
                  acc ^= gf_mul8(pkt_coeff[i], b);
               end
               push_rsp(0, 0, acc, len, ST_OK, 1);
            end
         end
         OP_CLEAR: begin
            n_pkts = 0;
            fill = 0;
            drawn = 0;
            push_rsp(0, 0, 0, 0, ST_OK, 1);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      coded_rsp_type want;
      if (reset) begin
         coded_q.delete();
         gen_state = 64'd0;
         n_pkts = 0;
         fill = 0;
         drawn = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coded_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: coeff=%h pkt=%0d byte=%h len=%0d st=%0d last=%b",
                           rsp_coeff, rsp_packet_index, rsp_coded_byte, rsp_coded_length,
                           rsp_status, rsp_last);
            end else begin
               want = coded_q.pop_front();
               if (want.coeff !== rsp_coeff || want.pkt !== rsp_packet_index ||
                   want.cbyte !== rsp_coded_byte || want.clen !== rsp_coded_length ||
                   want.status !== rsp_status || want.last !== rsp_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp coeff=%h pkt=%0d byte=%h len=%0d st=%0d last=%b, %s",
                              want.coeff, want.pkt, want.cbyte, want.clen, want.status,
                              want.last, $sformatf("got coeff=%h pkt=%0d byte=%h len=%0d st=%0d last=%b",
                              rsp_coeff, rsp_packet_index, rsp_coded_byte, rsp_coded_length,
                              rsp_status, rsp_last));
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == REG_SEED_ADDR)
            gen_state = pwdata;
         if (req_valid && !req_stall)
            predict(req_op, req_data_byte, req_byte_index);
      end
      pending = coded_q.size();
   end

endmodule

/* dv/rlnc_gf256_encoder_tb.sv */
`timescale 1ns / 1ps
module rlnc_gf256_encoder_tb;
   import rlnc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_op = 0;
   logic [7:0]  req_data_byte = 0;
   logic [8:0]  req_byte_index = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_coeff;
   logic [3:0]  rsp_packet_index;
   logic [7:0]  rsp_coded_byte;
   logic [8:0]  rsp_coded_length;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [63:0] pwdata = 0;
   logic [63:0] prdata;
   logic        pready;
   int          mismatches;
   int          pending;

   int burst_left = 0;
   int hold_reqs = 0;
   int rand_sent = 0;
   int max_len = 0;

   always #5 clock = ~clock;

   rlnc_gf256_encoder dut (.*);

   rlnc_stream_checker checker_i (.*);

   task automatic send(logic [2:0] op, logic [7:0] db, logic [8:0] bi);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1;
      req_op <= op;
      req_data_byte <= db;
      req_byte_index <= bi;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      // ignored items may still be in flight
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic [63:0] v);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= REG_SEED_ADDR;
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic load_packet(int len);
      for (int i = 0; i < len; i++) send(OP_BYTE, 8'($urandom), 9'($urandom_range(0, 256)));
      send(OP_END, 8'($urandom), 9'($urandom_range(0, 256)));
      if (len + 1 > max_len) max_len = len + 1;
   endtask

   // receiver: random stall density per stretch, long hold-off on request
   initial begin
      int hold_seen, hold_left, mode_left, pct;
      hold_seen = 0;
      hold_left = 0;
      mode_left = 0;
      pct = 0;
      forever begin
         @(posedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(16, 96);
               case ($urandom_range(0, 2))
                  0: pct = 0;
                  1: pct = 30;
                  default: pct = 70;
               endcase
            end
            mode_left--;
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("rlnc_gf256_encoder verification failed");
      $finish;
   end

   initial begin
      int npk, pick, plen;
      logic [63:0] seed_val;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      csr_write(64'd0);

      // empty store, zero-length packet, read before draw, seed zero gives ones
      send(OP_READ, 8'h00, 9'd0);
      send(OP_DRAW, 8'h00, 9'd0);
      send(OP_END, 8'h00, 9'd0);
      send(OP_READ, 8'h00, 9'd0);
      send(OP_DRAW, 8'h00, 9'd0);
      send(OP_READ, 8'h00, 9'd0);
      send(OP_READ, 8'h00, 9'd1);
      send(OP_BYTE, 8'hff, 9'd0);
      send(OP_BYTE, 8'h00, 9'h1ff & 9'd256);
      send(OP_END, 8'h00, 9'd0);
      send(OP_DRAW, 8'h00, 9'd0);
      for (int i = 0; i < 3; i++) send(OP_READ, 8'h00, 9'(i));
      send(OP_READ, 8'h00, 9'd256);
      send(3'd5, 8'hff, 9'd256);
      send(3'd6, 8'h55, 9'd0);
      send(3'd7, 8'haa, 9'd128);
      send(OP_CLEAR, 8'h00, 9'd0);
      drain();

      // full-length packet, full store, widest index, long receiver hold-off
      csr_write(64'hffff_ffff_ffff_ffff);
      send(OP_CLEAR, 8'h00, 9'd0);
      for (int i = 0; i < MAX_BYTES + 1; i++) send(OP_BYTE, 8'($urandom), 9'd0);
      send(OP_END, 8'h00, 9'd0);
      for (int p = 1; p < MAX_PACKETS; p++) load_packet($urandom_range(0, 3));
      send(OP_END, 8'h00, 9'd0);
      send(OP_BYTE, 8'h5a, 9'd0);
      send(OP_DRAW, 8'h00, 9'd0);
      send(OP_READ, 8'h00, 9'd256);
      send(OP_READ, 8'h00, 9'd255);
      send(OP_READ, 8'h00, 9'd0);
      hold_reqs++;
      for (int i = 0; i < 40; i++) send(OP_READ, 8'h00, 9'($urandom_range(0, 256)));
      drain();

      while (rand_sent < 150) begin
         pick = $urandom_range(0, 4);
         case (pick)
            0: seed_val = 64'd0;
            1: seed_val = 64'hffff_ffff_ffff_ffff;
            2: seed_val = 64'd1;
            default: seed_val = {$urandom, $urandom};
         endcase
         csr_write(seed_val);
         send(OP_CLEAR, 8'h00, 9'd0);
         max_len = 0;
         npk = ($urandom_range(0, 7) == 0) ? MAX_PACKETS : $urandom_range(1, 6);
         for (int p = 0; p < npk; p++) begin
            plen = $urandom_range(0, 8);
            load_packet(plen);
            rand_sent += plen + 1;
         end
         if ($urandom_range(0, 3) == 0) begin
            send(3'($urandom_range(0, 7)), 8'($urandom), 9'($urandom_range(0, 256)));
            rand_sent++;
         end
         send(OP_DRAW, 8'($urandom), 9'($urandom_range(0, 256)));
         rand_sent++;
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(0, 9) == 0)
               send(3'($urandom_range(0, 7)), 8'($urandom), 9'($urandom_range(0, 256)));
            else
               send(OP_READ, 8'($urandom), 9'($urandom_range(0, max_len + 1)));
            rand_sent++;
         end
         drain();
      end

      drain();
      if (mismatches == 0)
         $display("rlnc_gf256_encoder verification clean");
      else
         $display("rlnc_gf256_encoder verification failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/rlnc_pkg.sv
design/rlnc_ctrl.sv
design/rlnc_datapath.sv
design/rlnc_gf256_encoder.sv
dv/rlnc_stream_checker.sv
dv/rlnc_gf256_encoder_tb.sv
